/* hdl/rgb_to_yuv420_converter_unit_assert.svh */
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define RY420_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rgb_to_yuv420_converter_unit: assertion failed");

// Checked on every clock edge, reset included.
`define RY420_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rgb_to_yuv420_converter_unit: assertion failed");

`else

`define RY420_ASSERT_RST(lbl, clk, rst_n, prop)
`define RY420_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hdl/ry420_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter package
// Shared payload types, register codes and default sizes.
// ----------------------------------------------------------------------------
package ry420_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FRAC_BITS_DEF = 16;

    // Rows per frame never exceed this.
    localparam int MAX_ROWS = 4096;
    localparam int ROW_W    = 12;

    localparam int PIX_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma_valid;
        logic [PIX_W-1:0] cb_average;
        logic [PIX_W-1:0] cr_average;
        logic             frame_end;
    } t_result;

    // Raster position of the pixel about to be taken.
    typedef struct packed {
        logic col_odd;
        logic row_odd;
        logic frame_end;
    } t_pos;

endpackage

/* hdl/rgb_to_yuv420_converter_unit.sv */
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter
// Full-range BT.601 luma per pixel and 2x2 averaged chroma from raster RGB.
// ----------------------------------------------------------------------------
// The converter takes one RGB pixel per clock in raster order and returns one
// item per pixel: its luma, and on the pixel at odd column and odd row the Cb
// and Cr averages of the 2x2 block that pixel closes (chroma_valid high, both
// averages zero otherwise). frame_end marks the last pixel of each frame as
// set by frame_width and frame_height. Each item passes the input register, then
// the result register, and a new item is taken every clock as long as the result
// side keeps up; the rate is set by the single pass of constant multiplies,
// clamps and the two chroma adds between those registers. Cb and Cr pair sums
// of each even row are parked in a line store of (MAX_WIDTH+1)/2 entries, read
// on the odd row through the store's registered read port as each pixel enters
// the input register. The line store needs no clearing after reset, since every
// entry is written on an even row before the odd row reads it. The user must
// write frame size registers only while the block is empty; the block does not
// enforce it. A new size takes effect with the next pixel taken, and a column or
// row count already at or past it ends the row or the frame on that pixel.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_unit #(
    parameter int MAX_WIDTH = ry420_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = ry420_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel input.
    input  logic                             i_valid,
    output logic                             o_stall,
    input  ry420_pkg::t_pixel                i_pixel,
    // Result output.
    output logic                             o_valid,
    input  logic                             i_stall,
    output ry420_pkg::t_result               o_result,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ry420_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ry420_pkg::CFG_DATA_W-1:0] i_cfg_data
);

`include "rgb_to_yuv420_converter_unit_assert.svh"

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = $clog2(LINE_DEPTH);
    // Clamped chroma, pair sum and block sum widths.
    localparam int CHW        = FRAC_BITS + 8;
    localparam int PSW        = FRAC_BITS + 9;
    localparam int QSW        = FRAC_BITS + 10;

    logic                 in_acc;
    logic                 s1_adv;
    logic                 r_s1_valid;
    logic                 n_s1_valid;
    ry420_pkg::t_pixel    r_s1_pixel;
    ry420_pkg::t_pos      r_s1_pos;
    logic [AW-1:0]        r_s1_idx;
    logic                 r_out_valid;
    logic                 n_out_valid;
    ry420_pkg::t_result   r_result;
    ry420_pkg::t_result   n_result;
    logic [CHW-1:0]       r_left_cb;
    logic [CHW-1:0]       r_left_cr;

    ry420_pkg::t_pos      cur_pos;
    logic [AW-1:0]        cur_idx;
    logic [7:0]           luma;
    logic [CHW-1:0]       cb;
    logic [CHW-1:0]       cr;
    logic [PSW-1:0]       pair_cb;
    logic [PSW-1:0]       pair_cr;
    logic [2*PSW-1:0]     line_rd_data;
    logic [QSW-1:0]       quad_cb;
    logic [QSW-1:0]       quad_cr;
    logic                 line_wr;
    logic                 chroma_valid;
    logic                 left_load;
    logic                 pos_home;

    // Handshake. The input register moves on whenever the result register is
    // empty or being emptied, so an item can enter on every clock.
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    ry420_raster #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (in_acc),
        .o_pos       (cur_pos),
        .o_pair_idx  (cur_idx)
    );

    // The raster position sits at the top left of a frame.
    assign pos_home = (cur_idx == '0) && !cur_pos.col_odd && !cur_pos.row_odd;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Input register. The position travels with the pixel.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel <= i_pixel;
            r_s1_pos   <= cur_pos;
            r_s1_idx   <= cur_idx;
        end
    end

    // Line store. The read for a pixel is issued as it enters the input
    // register, so the data is ready while that pixel is converted. The even
    // row entry was written before any later pixel could enter.
    assign line_wr = s1_adv && r_s1_pos.col_odd && !r_s1_pos.row_odd;

    ry420_ram #(
        .WIDTH (2 * PSW),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (r_s1_idx),
        .i_wr_data ({pair_cb, pair_cr}),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_idx),
        .o_rd_data (line_rd_data)
    );

    ry420_csc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_csc (
        .i_pixel (r_s1_pixel),
        .o_luma  (luma),
        .o_cb    (cb),
        .o_cr    (cr)
    );

    // Horizontal pair sums, then the full 2x2 block sums.
    assign pair_cb = PSW'(r_left_cb) + PSW'(cb);
    assign pair_cr = PSW'(r_left_cr) + PSW'(cr);
    assign quad_cb = QSW'(line_rd_data[2*PSW-1:PSW]) + QSW'(pair_cb);
    assign quad_cr = QSW'(line_rd_data[PSW-1:0]) + QSW'(pair_cr);

    assign chroma_valid = r_s1_pos.col_odd && r_s1_pos.row_odd;

    // The block average drops the fraction and the divide by four together.
    always_comb begin
        n_result.luma         = luma;
        n_result.chroma_valid = chroma_valid;
        n_result.cb_average   = chroma_valid ? quad_cb[QSW-1:FRAC_BITS+2] : '0;
        n_result.cr_average   = chroma_valid ? quad_cr[QSW-1:FRAC_BITS+2] : '0;
        n_result.frame_end    = r_s1_pos.frame_end;
    end

    // The even-column pixel's chroma waits here for its right neighbor.
    assign left_load = s1_adv && !r_s1_pos.col_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cb <= '0;
            r_left_cr <= '0;
        end else if (left_load) begin
            r_left_cb <= cb;
            r_left_cr <= cr;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // After the last pixel of a frame the raster position is back at the top.
    `RY420_ASSERT_RST(a_frame_wrap, i_clk, i_rst_n, in_acc && cur_pos.frame_end |=> pos_home)

    // Chroma is only produced by a pixel at odd column.
    `RY420_ASSERT_RST(a_chroma_odd_col, i_clk, i_rst_n, left_load |=> !r_result.chroma_valid)

    // A held item in the input register keeps its pixel.
    `RY420_ASSERT_RST(a_s1_hold, i_clk, i_rst_n, o_stall |=> r_s1_valid && $stable(r_s1_pixel))

    // Reset empties both registers.
    `RY420_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid && !r_s1_valid)

endmodule

/* hdl/ry420_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ry420_ram #(
    parameter int WIDTH = 2 * (ry420_pkg::FRAC_BITS_DEF + 9),
    parameter int DEPTH = (ry420_pkg::MAX_WIDTH_DEF + 1) / 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/ry420_csc.sv */
// ----------------------------------------------------------------------------
// Color space conversion
// Fixed-point luma and clamped per-pixel Cb and Cr from one RGB pixel.
// ----------------------------------------------------------------------------
module ry420_csc #(
    parameter int FRAC_BITS = ry420_pkg::FRAC_BITS_DEF
) (
    input  ry420_pkg::t_pixel      i_pixel,
    output logic [7:0]             o_luma,
    output logic [FRAC_BITS+7:0]   o_cb,
    output logic [FRAC_BITS+7:0]   o_cr
);

    // Signed working width covers the offset plus the largest weighted sum.
    localparam int SW = FRAC_BITS + 10;

    // Coefficients k/10000 rounded half up to FRAC_BITS fractional bits.
    localparam logic signed [SW-1:0] C_YR =
        SW'(((64'd2989 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_YG =
        SW'(((64'd5866 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_YB =
        SW'(((64'd1145 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_UR =
        SW'(((64'd1688 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_UG =
        SW'(((64'd3312 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_HALF =
        SW'(((64'd5000 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_VG =
        SW'(((64'd4184 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] C_VB =
        SW'(((64'd816 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic signed [SW-1:0] OFFSET = SW'(64'd128 << FRAC_BITS);
    localparam logic signed [SW-1:0] TOP    = SW'(64'd255 << FRAC_BITS);

    logic signed [SW-1:0]        red_s;
    logic signed [SW-1:0]        green_s;
    logic signed [SW-1:0]        blue_s;
    logic signed [SW-1:0]        y_sum;
    logic signed [SW-1:0]        cb_sum;
    logic signed [SW-1:0]        cr_sum;
    logic [SW-FRAC_BITS-1:0]     y_int;

    // Saturate a chroma sum to 0..255 with its fraction kept.
    function automatic logic [FRAC_BITS+7:0] clamp_chroma(input logic signed [SW-1:0] v);
        logic [FRAC_BITS+7:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > TOP) begin
            res = TOP[FRAC_BITS+7:0];
        end else begin
            res = v[FRAC_BITS+7:0];
        end
        return res;
    endfunction

    assign red_s   = SW'(i_pixel.red);
    assign green_s = SW'(i_pixel.green);
    assign blue_s  = SW'(i_pixel.blue);

    assign y_sum  = red_s * C_YR + green_s * C_YG + blue_s * C_YB;
    assign cb_sum = OFFSET - red_s * C_UR - green_s * C_UG + blue_s * C_HALF;
    assign cr_sum = OFFSET + red_s * C_HALF - green_s * C_VG - blue_s * C_VB;

    // Luma is never negative, so only the top needs a limit.
    assign y_int  = y_sum[SW-1:FRAC_BITS];
    assign o_luma = (y_int > (SW-FRAC_BITS)'(255)) ? 8'd255 : y_int[7:0];

    assign o_cb = clamp_chroma(cb_sum);
    assign o_cr = clamp_chroma(cr_sum);

endmodule

/* hdl/ry420_raster.sv */
// ----------------------------------------------------------------------------
// Raster tracker
// Frame size registers and the column and row position of the next pixel.
// ----------------------------------------------------------------------------
module ry420_raster #(
    parameter int MAX_WIDTH = ry420_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [ry420_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ry420_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_advance,
    output ry420_pkg::t_pos                      o_pos,
    output logic [$clog2((MAX_WIDTH+1)/2)-1:0]   o_pair_idx
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int XW         = AW + 1;

    logic [ry420_pkg::FW_W-1:0]  r_frame_width;
    logic [ry420_pkg::FH_W-1:0]  r_frame_height;
    logic [XW-1:0]               r_col;
    logic [XW-1:0]               n_col;
    logic [ry420_pkg::ROW_W-1:0] r_row;
    logic [ry420_pkg::ROW_W-1:0] n_row;
    logic                        row_end;
    logic                        frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ry420_pkg::FRAME_WIDTH_RST;
            r_frame_height <= ry420_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ry420_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[ry420_pkg::FW_W-1:0];
                end
                ry420_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[ry420_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A zero size behaves as one; a size past the maximum ends at the maximum.
    assign row_end = (32'(r_col) + 32'd1 >= 32'(r_frame_width)) ||
                     (32'(r_col) + 32'd1 >= 32'(MAX_WIDTH));
    assign frame_last = row_end &&
                        ((32'(r_row) + 32'd1 >= 32'(r_frame_height)) ||
                         (32'(r_row) + 32'd1 >= 32'(ry420_pkg::MAX_ROWS)));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_last ? '0 : r_row + ry420_pkg::ROW_W'(1);
        end else begin
            n_col = r_col + XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.col_odd   = r_col[0];
    assign o_pos.row_odd   = r_row[0];
    assign o_pos.frame_end = frame_last;
    assign o_pair_idx      = r_col[XW-1:1];

endmodule

/* tb/rgb_to_yuv420_converter_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter testbench
// Streams raster RGB pixels through the converter under several frame sizes,
// predicts luma, 2x2 chroma averages and frame ends in a local fixed-point
// model, and checks every result item field by field in order of arrival.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter_unit_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    // Two register stages inside, so a few cycles cover anything in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam int PIX_W      = ry420_pkg::PIX_W;
    localparam int FW_W       = ry420_pkg::FW_W;
    localparam int FH_W       = ry420_pkg::FH_W;
    localparam int CFG_IDX_W  = ry420_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ry420_pkg::CFG_DATA_W;
    localparam int FRAC       = ry420_pkg::FRAC_BITS_DEF;
    localparam int MAX_W      = ry420_pkg::MAX_WIDTH_DEF;
    localparam int LINE_DEPTH = (MAX_W + 1) / 2;

    // Coefficients k/10000 rounded half up to FRAC fractional bits.
    localparam longint COEF_SCALE    = 10000;
    localparam longint Y_FROM_R      = ((longint'(2989) << FRAC) + 5000) / COEF_SCALE;
    localparam longint Y_FROM_G      = ((longint'(5866) << FRAC) + 5000) / COEF_SCALE;
    localparam longint Y_FROM_B      = ((longint'(1145) << FRAC) + 5000) / COEF_SCALE;
    localparam longint CB_FROM_R     = ((longint'(1688) << FRAC) + 5000) / COEF_SCALE;
    localparam longint CB_FROM_G     = ((longint'(3312) << FRAC) + 5000) / COEF_SCALE;
    localparam longint CHROMA_HALF   = ((longint'(5000) << FRAC) + 5000) / COEF_SCALE;
    localparam longint CR_FROM_G     = ((longint'(4184) << FRAC) + 5000) / COEF_SCALE;
    localparam longint CR_FROM_B     = ((longint'(816) << FRAC) + 5000) / COEF_SCALE;
    localparam longint CHROMA_OFFSET = longint'(128) << FRAC;
    localparam longint CHROMA_TOP    = longint'(255) << FRAC;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    ry420_pkg::t_pixel       i_pixel     = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    ry420_pkg::t_result      o_result;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = ry420_pkg::REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    rgb_to_yuv420_converter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Local copy of the converter state, advanced once per accepted pixel.
    logic [FW_W-1:0]    width_reg  = ry420_pkg::FRAME_WIDTH_RST;
    logic [FH_W-1:0]    height_reg = ry420_pkg::FRAME_HEIGHT_RST;
    longint             pair_cb_line [LINE_DEPTH];
    longint             pair_cr_line [LINE_DEPTH];
    longint             left_cb = 0;
    longint             left_cr = 0;
    int                 col_pos = 0;
    int                 row_pos = 0;
    ry420_pkg::t_result pending_yuv [$];

    int   error_count     = 0;
    int   pixels_sent     = 0;
    int   results_checked = 0;
    int   chroma_blocks   = 0;
    int   frames_done     = 0;
    int   cycle_count     = 0;
    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    logic hold_start      = 1'b0;
    int   hold_count      = 0;

    // Directed pixels, sent as 2x2 frames: rails, primaries, chroma that
    // saturates at the top, chroma near the floor, and a few odd values.
    logic [23:0] directed_rgb [24] = '{
        24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
        24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF,
        24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000,
        24'hFFFF00, 24'h00FFFF, 24'hFFFF00, 24'h00FFFF,
        24'h010203, 24'h808080, 24'hFE017F, 24'h55AA2A
    };

    function automatic longint clamp_chroma(input longint v);
        if (v < 0) return 0;
        if (v > CHROMA_TOP) return CHROMA_TOP;
        return v;
    endfunction

    // Works out the result item of one pixel and queues it.
    function automatic void convert_pixel(input ry420_pkg::t_pixel px);
        longint             r, g, b, luma_val, cb, cr, avg_cb, avg_cr;
        int                 eff_w, eff_h, idx;
        ry420_pkg::t_result res;
        r = longint'(px.red);
        g = longint'(px.green);
        b = longint'(px.blue);
        // Frame sizes outside the legal range saturate, width to 1..MAX_W
        // and height to 1..MAX_ROWS.
        eff_w = int'(width_reg);
        if (eff_w < 1) eff_w = 1;
        if (eff_w > MAX_W) eff_w = MAX_W;
        eff_h = int'(height_reg);
        if (eff_h < 1) eff_h = 1;
        if (eff_h > ry420_pkg::MAX_ROWS) eff_h = ry420_pkg::MAX_ROWS;

        res = '0;
        luma_val = (r * Y_FROM_R + g * Y_FROM_G + b * Y_FROM_B) >>> FRAC;
        if (luma_val > 255) luma_val = 255;
        res.luma = luma_val[PIX_W-1:0];
        cb = clamp_chroma(CHROMA_OFFSET - r * CB_FROM_R - g * CB_FROM_G + b * CHROMA_HALF);
        cr = clamp_chroma(CHROMA_OFFSET + r * CHROMA_HALF - g * CR_FROM_G - b * CR_FROM_B);

        if (col_pos[0] == 1'b0) begin
            left_cb = cb;
            left_cr = cr;
        end else begin
            idx = col_pos >> 1;
            if (row_pos[0] == 1'b0) begin
                pair_cb_line[idx] = left_cb + cb;
                pair_cr_line[idx] = left_cr + cr;
            end else begin
                avg_cb = (pair_cb_line[idx] + left_cb + cb) >> (FRAC + 2);
                avg_cr = (pair_cr_line[idx] + left_cr + cr) >> (FRAC + 2);
                res.chroma_valid = 1'b1;
                res.cb_average   = avg_cb[PIX_W-1:0];
                res.cr_average   = avg_cr[PIX_W-1:0];
            end
        end

        // A count at or past a size that shrank mid-frame ends the row or frame.
        if (col_pos + 1 >= eff_w) begin
            res.frame_end = (row_pos + 1 >= eff_h);
            col_pos = 0;
            row_pos = res.frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        pending_yuv.push_back(res);
        pixels_sent++;
    endfunction

    // Roughly one level in eight sits on a rail to work the clamps.
    function automatic logic [PIX_W-1:0] random_level();
        logic [31:0] draw;
        draw = $urandom;
        if (draw[31:29] == 3'b000) return {PIX_W{draw[28]}};
        return draw[PIX_W-1:0];
    endfunction

    function automatic void check_field(input string field, input logic [PIX_W-1:0] want,
                                        input logic [PIX_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endfunction

    // Offers one pixel, with random idle cycles ahead of it, and holds it
    // steady until the converter takes it.
    task automatic send_pixel(input ry420_pkg::t_pixel px);
        while (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        convert_pixel(px);
    endtask

    task automatic send_random_pixels(input int count);
        ry420_pkg::t_pixel px;
        for (int i = 0; i < count; i++) begin
            px.red   = random_level();
            px.green = random_level();
            px.blue  = random_level();
            send_pixel(px);
        end
    endtask

    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (pending_yuv.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write valid high so that back-to-back writes stay one item
    // per edge; the caller lowers it after the last one.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ry420_pkg::REG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
        else height_reg = data[FH_W-1:0];
    endtask

    task automatic resize_frame(input logic [CFG_DATA_W-1:0] width,
                                input logic [CFG_DATA_W-1:0] height);
        wait_for_idle();
        write_register(ry420_pkg::REG_FRAME_WIDTH, width);
        write_register(ry420_pkg::REG_FRAME_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    // One full row at the reset width and the first block of the next row,
    // with no register written.
    task automatic test_reset_defaults();
        send_random_pixels(int'(ry420_pkg::FRAME_WIDTH_RST) + 2);
    endtask

    // Size changes while a frame is open: the row count already past the new
    // height, and later the column count past a narrower width on an odd row.
    // Only shrinking or even-row starts are used, so every line entry that an
    // odd row reads was stored by the even row above it.
    task automatic test_midframe_resize();
        resize_frame(4, 1);
        send_random_pixels(2);
        resize_frame(16, 2);
        send_random_pixels(16 + 5);
        resize_frame(3, 2);
        send_random_pixels(1);
    endtask

    task automatic test_directed_extremes();
        resize_frame(2, 2);
        foreach (directed_rgb[i]) send_pixel(ry420_pkg::t_pixel'(directed_rgb[i]));
    endtask

    // An odd trailing column or row carries no chroma.
    task automatic test_odd_trailing();
        resize_frame(5, 3);
        send_random_pixels(15);
        resize_frame(3, 5);
        send_random_pixels(15);
    endtask

    // Sizes that saturate at both ends, a zero width, and the widest legal
    // width cut short by a narrower one on its even row.
    task automatic test_size_extremes();
        resize_frame(13'h1FFF, 0);
        send_random_pixels(40);
        resize_frame(0, 13'h1FFF);
        send_random_pixels(50);
        resize_frame(2, 2);
        send_random_pixels(2);
        resize_frame(CFG_DATA_W'(MAX_W), 2);
        send_random_pixels(30);
        resize_frame(8, 2);
        send_random_pixels(1 + 8);
    endtask

    // The result side holds off for a long stretch while pixels keep coming,
    // so the converter fills and stalls its input.
    task automatic test_backpressure_fill();
        resize_frame(32, 8);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        send_random_pixels(64);
    endtask

    // Mostly whole frames of small random size; some frames are cut short
    // and resized while open.
    task automatic test_random_frames(input int item_goal);
        int sent, w, h, pick, count;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 70) w = $urandom_range(2, 12);
            else if (pick < 95) w = $urandom_range(13, 48);
            else w = $urandom_range(49, 160);
            h = (w > 48) ? $urandom_range(2, 3) : $urandom_range(2, 7);
            // Widening is safe only where an even row starts; elsewhere an odd
            // row could read line entries that were never stored.
            if (!(col_pos == 0 && row_pos[0] == 1'b0) && w > int'(width_reg))
                w = int'(width_reg);
            resize_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
            count = w * h;
            if ($urandom_range(99) < 15) count = $urandom_range(1, count - 1);
            send_random_pixels(count);
            sent += count;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_start) hold_count <= HOLD_CYCLES;
        else if (hold_count != 0) hold_count <= hold_count - 1;
    end

    always @(posedge i_clk) begin
        i_stall <= (hold_count != 0) || (int'($urandom_range(99)) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        ry420_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_yuv.size() == 0) begin
                $error("result item arrived with no pixel outstanding");
                error_count++;
            end else begin
                want = pending_yuv.pop_front();
                results_checked++;
                check_field("luma", want.luma, o_result.luma);
                check_field("chroma_valid", PIX_W'(want.chroma_valid),
                            PIX_W'(o_result.chroma_valid));
                check_field("cb_average", want.cb_average, o_result.cb_average);
                check_field("cr_average", want.cr_average, o_result.cr_average);
                check_field("frame_end", PIX_W'(want.frame_end),
                            PIX_W'(o_result.frame_end));
                if (want.chroma_valid) chroma_blocks++;
                if (want.frame_end) frames_done++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout with %0d result items outstanding", pending_yuv.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        recv_stall_pct <= 51;
        test_reset_defaults();
        test_midframe_resize();
        test_directed_extremes();
        test_odd_trailing();
        test_random_frames(160);
        wait_for_idle();

        send_idle_pct = 51;
        recv_stall_pct <= 20;
        test_size_extremes();
        test_random_frames(160);
        wait_for_idle();

        send_idle_pct = 0;
        recv_stall_pct <= 0;
        test_backpressure_fill();
        test_random_frames(160);
        wait_for_idle();

        $display("Converted %0d pixels over %0d closed frames, %0d chroma blocks averaged.",
                 pixels_sent, frames_done, chroma_blocks);
        $display("Sizes ran from zero to oversized with mid-frame changes, %0d results checked.",
                 results_checked);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
